// ===== src/kes_pkg.sv =====
package kes_pkg;

    // Storage geometry
    localparam int SLOTS       = 128;
    localparam int DATA_WIDTH  = 32;
    localparam int RANK_WIDTH  = 7;
    localparam int SEL_WIDTH   = 32;
    localparam int COUNT_WIDTH = $clog2(SLOTS + 1);

    // Input transaction
    typedef struct packed {
        logic [DATA_WIDTH-1:0] sample_value;
        logic                  last;
        logic [RANK_WIDTH-1:0] rank;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic [SEL_WIDTH-1:0] selected;
        logic                 rank_error;
        logic                 overflow;
    } t_out_item;

    // What a cell shows to its right-hand neighbor
    typedef struct packed {
        logic                  valid;
        logic                  gt;
        logic [DATA_WIDTH-1:0] value;
    } t_link;

    // Chain controls broadcast to every cell
    typedef struct packed {
        logic                  insert;
        logic                  shift;
        logic                  clear;
        logic [DATA_WIDTH-1:0] value;
    } t_chain_ctrl;

endpackage

// ===== src/kes_cell.sv =====
module kes_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kes_pkg::t_chain_ctrl            i_ctrl,
    input  kes_pkg::t_link                  i_left,
    input  logic [kes_pkg::DATA_WIDTH-1:0]  i_right_value,
    output kes_pkg::t_link                  o_link
);

    logic                           r_valid;
    logic [kes_pkg::DATA_WIDTH-1:0] r_value;
    logic [kes_pkg::DATA_WIDTH-1:0] n_value;
    logic                           gt;
    logic                           take;

    // Compare own entry against the broadcast value
    assign gt   = r_valid && (r_value > i_ctrl.value);
    assign take = gt || (!r_valid && i_left.valid);

    assign o_link.valid = r_valid;
    assign o_link.gt    = gt;
    assign o_link.value = r_value;

    // Shift left while seeking, or make room and insert in order
    always_comb begin
        n_value = r_value;
        priority if (i_ctrl.shift) begin
            n_value = i_right_value;
        end else if (i_ctrl.insert && take) begin
            n_value = i_left.gt ? i_left.value : i_ctrl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // Occupied cells form a prefix of the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.insert && i_left.valid) begin
            r_valid <= 1'b1;
        end
    end

endmodule

// ===== src/kth_element_select_core.sv =====
// Load: one transaction per cycle while not busy; each number is sorted into the cell chain as it arrives.
// Select: after the last transaction the block is busy while the chain shifts rank places
// toward cell 0 (no shift on a rank error), then o_done pulses for one cycle.
// No new numbers are taken while a selection is in progress (o_busy high).
// Reset (synchronous, active low) empties the chain and drops any group in progress.
// The receiver cannot stall: each result is flagged by o_done for exactly one cycle.
module kth_element_select_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  kes_pkg::t_in_item   i_item,
    output logic                o_busy,
    output logic                o_done,
    output kes_pkg::t_out_item  o_result
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEEK = 1'b1;

    logic                              r_state;
    logic                              n_state;
    logic [kes_pkg::COUNT_WIDTH-1:0]   r_count;
    logic [kes_pkg::COUNT_WIDTH-1:0]   n_count;
    logic                              r_dropped;
    logic                              n_dropped;
    logic [kes_pkg::RANK_WIDTH-1:0]    r_sel;
    logic [kes_pkg::RANK_WIDTH-1:0]    n_sel;
    logic                              r_err;
    logic                              n_err;
    logic                              r_done;
    logic                              n_done;
    kes_pkg::t_out_item                r_result;
    kes_pkg::t_out_item                n_result;

    logic                              accept;
    logic                              full;
    logic [kes_pkg::COUNT_WIDTH-1:0]   count_after;
    logic                              emit;
    kes_pkg::t_chain_ctrl              ctrl;
    kes_pkg::t_link                    links [kes_pkg::SLOTS];

    assign accept      = i_start && (r_state == ST_IDLE);
    assign full        = (r_count == kes_pkg::COUNT_WIDTH'(kes_pkg::SLOTS));
    assign count_after = full ? r_count : r_count + kes_pkg::COUNT_WIDTH'(1);
    assign emit        = (r_state == ST_SEEK) && (r_err || (r_sel == '0));

    // Broadcast controls to the chain
    assign ctrl.insert = accept && !full;
    assign ctrl.shift  = (r_state == ST_SEEK) && !emit;
    assign ctrl.clear  = emit;
    assign ctrl.value  = i_item.sample_value;

    // Cell chain: cell 0 sees an always-full, never-greater neighbor on its left
    for (genvar g = 0; g < kes_pkg::SLOTS; g++) begin : g_cell
        kes_pkg::t_link                 left;
        logic [kes_pkg::DATA_WIDTH-1:0] right_value;

        if (g == 0) begin : g_head
            assign left = '{valid: 1'b1, gt: 1'b0, value: '0};
        end else begin : g_body
            assign left = links[g-1];
        end

        if (g == kes_pkg::SLOTS - 1) begin : g_tail
            assign right_value = '0;
        end else begin : g_mid
            assign right_value = links[g+1].value;
        end

        kes_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (ctrl),
            .i_left        (left),
            .i_right_value (right_value),
            .o_link        (links[g])
        );
    end

    // Group bookkeeping and result sequencing
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        n_sel     = r_sel;
        n_err     = r_err;
        n_done    = 1'b0;
        n_result  = r_result;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_count   = count_after;
                    n_dropped = r_dropped || full;
                    if (i_item.last) begin
                        n_sel   = i_item.rank;
                        n_err   = int'(i_item.rank) >= int'(count_after);
                        n_state = ST_SEEK;
                    end
                end
            end
            ST_SEEK: begin
                if (emit) begin
                    n_done              = 1'b1;
                    n_result.selected   = r_err ? '0
                                                : kes_pkg::SEL_WIDTH'(links[0].value);
                    n_result.rank_error = r_err;
                    n_result.overflow   = r_dropped;
                    n_count             = '0;
                    n_dropped           = 1'b0;
                    n_state             = ST_IDLE;
                end else begin
                    n_sel = r_sel - kes_pkg::RANK_WIDTH'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel    <= n_sel;
        r_err    <= n_err;
        r_result <= n_result;
    end

    assign o_busy   = (r_state == ST_SEEK);
    assign o_done   = r_done;
    assign o_result = r_result;

    // Checks
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result shown while still seeking");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= kes_pkg::COUNT_WIDTH'(kes_pkg::SLOTS))
        else $error("element count beyond capacity");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.rank_error) |-> (o_result.selected == '0))
        else $error("rank error with nonzero selection");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_item.last) |=> o_busy)
        else $error("last transaction did not start selection");

endmodule

// ===== test/kth_element_select_core_tb.sv =====
module kth_element_select_core_tb;

    // Sorted-store model and queue of selections still owed by the block
    class kth_scoreboard;
        logic [kes_pkg::DATA_WIDTH-1:0] ordered [kes_pkg::SLOTS];
        int unsigned                    fill;
        bit                             spilled;
        kes_pkg::t_out_item             pending [$];
        int                             errors;
        int                             results_seen;
        int                             rank_errors_seen;
        int                             overflows_seen;

        function new();
            fill    = 0;
            spilled = 1'b0;
            errors  = 0;
            results_seen     = 0;
            rank_errors_seen = 0;
            overflows_seen   = 0;
        endfunction

        // Print one mismatch line and count it
        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Insert an accepted number in ascending order; predict the selection on last
        function void note_input(kes_pkg::t_in_item it);
            int unsigned        pos;
            kes_pkg::t_out_item want;
            if (fill >= kes_pkg::SLOTS) begin
                spilled = 1'b1;
            end else begin
                pos = fill;
                while (pos > 0 && ordered[pos-1] > it.sample_value) begin
                    ordered[pos] = ordered[pos-1];
                    pos--;
                end
                ordered[pos] = it.sample_value;
                fill++;
            end
            if (it.last) begin
                if (it.rank < fill) begin
                    want.selected   = ordered[it.rank];
                    want.rank_error = 1'b0;
                end else begin
                    want.selected   = '0;
                    want.rank_error = 1'b1;
                end
                want.overflow = spilled;
                pending = {pending, want};
                fill    = 0;
                spilled = 1'b0;
            end
        endfunction

        // Compare one result transaction against the oldest prediction
        task check_result(kes_pkg::t_out_item got);
            kes_pkg::t_out_item want;
            results_seen++;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing outstanding: %h", got));
                return;
            end
            want = pending.pop_front();
            if (want.rank_error) rank_errors_seen++;
            if (want.overflow) overflows_seen++;
            if (got.selected !== want.selected) begin
                report($sformatf("selected %h, want %h (result %0d)",
                                 got.selected, want.selected, results_seen));
            end
            if (got.rank_error !== want.rank_error) begin
                report($sformatf("rank_error %b, want %b (result %0d)",
                                 got.rank_error, want.rank_error, results_seen));
            end
            if (got.overflow !== want.overflow) begin
                report($sformatf("overflow %b, want %b (result %0d)",
                                 got.overflow, want.overflow, results_seen));
            end
        endtask
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    kes_pkg::t_in_item  i_item  = '0;
    logic               o_busy;
    logic               o_done;
    kes_pkg::t_out_item o_result;

    kth_scoreboard sb;
    bit            calm        = 1'b0;
    int            items_sent  = 0;
    int            groups_sent = 0;

    kth_element_select_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog
    initial begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Sample accepted transactions and results at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) sb.note_input(i_item);
            if (o_done) sb.check_result(o_result);
        end
    end

    // Offer one transaction, idling at random first; return in the accepting step
    task automatic send_item(input logic [kes_pkg::DATA_WIDTH-1:0] value, input logic last,
                             input logic [kes_pkg::RANK_WIDTH-1:0] rank);
        kes_pkg::t_in_item it;
        it.sample_value = value;
        it.last         = last;
        it.rank         = rank;
        while (!calm && $urandom_range(0, 99) < 38) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy);
        items_sent++;
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic hold_until_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Mix of full-range, clustered (duplicates) and boundary values
    function automatic logic [kes_pkg::DATA_WIDTH-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return $urandom;
        if (sel < 75) return $urandom_range(0, 7);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return {1'b1, {(kes_pkg::DATA_WIDTH-1){1'b0}}};
            default: return {1'b0, {(kes_pkg::DATA_WIDTH-1){1'b1}}};
        endcase
    endfunction

    // Load one group of random numbers; the final one carries the rank
    task automatic send_group(input int size, input logic [kes_pkg::RANK_WIDTH-1:0] rank);
        for (int k = 0; k < size - 1; k++) begin
            send_item(pick_value(), 1'b0, kes_pkg::RANK_WIDTH'($urandom_range(0, 127)));
        end
        send_item(pick_value(), 1'b1, rank);
        groups_sent++;
    endtask

    initial begin
        int size;
        int stored;
        int sel;
        logic [kes_pkg::RANK_WIDTH-1:0] rank;

        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single-element groups: zero, all ones, rank just past the count
        send_item('0, 1'b1, 7'd0);
        send_item('1, 1'b1, 7'd0);
        send_item(32'd5, 1'b1, 7'd1);
        groups_sent += 3;
        // Extremes mixed; pick the top position
        send_item('1, 1'b0, 7'd127);
        send_item('0, 1'b0, 7'd0);
        send_item(32'd7, 1'b1, 7'd2);
        // Duplicates keep their place
        send_item(32'd4, 1'b0, 7'd99);
        send_item(32'd4, 1'b0, 7'd0);
        send_item(32'd4, 1'b0, 7'd64);
        send_item(32'd2, 1'b1, 7'd1);
        // Largest rank against a small group
        send_item(32'h8000_0000, 1'b0, 7'd3);
        send_item(32'h7fff_ffff, 1'b0, 7'd5);
        send_item(32'd1, 1'b1, 7'd127);
        // Descending arrival, smallest selected
        send_item(32'd50, 1'b0, 7'd0);
        send_item(32'd40, 1'b0, 7'd0);
        send_item(32'd30, 1'b0, 7'd0);
        send_item(32'd20, 1'b0, 7'd0);
        send_item(32'd10, 1'b1, 7'd0);
        // Ascending arrival, middle selected
        send_item(32'd100, 1'b0, 7'd42);
        send_item(32'd200, 1'b0, 7'd85);
        send_item(32'd300, 1'b1, 7'd1);
        groups_sent += 5;
        hold_until_drained();

        // Random groups: mostly small, a few at or past capacity
        while (items_sent < 900) begin
            calm = (groups_sent >= 25 && groups_sent < 60);
            sel  = $urandom_range(0, 99);
            if (groups_sent == 12) size = kes_pkg::SLOTS;
            else if (groups_sent == 30) size = kes_pkg::SLOTS + 3;
            else if (sel < 4) size = $urandom_range(kes_pkg::SLOTS - 8, kes_pkg::SLOTS + 12);
            else if (sel < 12) size = $urandom_range(17, 40);
            else size = $urandom_range(1, 16);
            stored = (size > kes_pkg::SLOTS) ? kes_pkg::SLOTS : size;
            if (groups_sent == 12 || groups_sent == 30) begin
                rank = kes_pkg::RANK_WIDTH'(stored - 1);
            end else if ($urandom_range(0, 99) < 80) begin
                rank = kes_pkg::RANK_WIDTH'($urandom_range(0, stored - 1));
            end else begin
                rank = kes_pkg::RANK_WIDTH'($urandom_range(0, 127));
            end
            send_group(size, rank);
            if ($urandom_range(0, 39) == 0) hold_until_drained();
        end

        // Drain outstanding results, then let the select phase settle
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (kes_pkg::SLOTS + 8) @(posedge i_clk);

        $display("Loaded %0d numbers in %0d groups; checked %0d selections",
                 items_sent, groups_sent, sb.results_seen);
        $display("Covered %0d out-of-range ranks and %0d groups that exceeded capacity",
                 sb.rank_errors_seen, sb.overflows_seen);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
